// ----- rtl/uok_pkg.sv -----
// uok_pkg: types and constants shared by the modem response detector.
// No dependencies; imported by uart_response_ok_detector.
`default_nettype none

package uok_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_RX_BYTE    = 2'd0,
        KIND_READ       = 2'd1,
        KIND_START_WAIT = 2'd2,
        KIND_TICK       = 2'd3
    } kind_t;

    // Matcher states for CR LF 'O' 'K' CR LF
    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_CR     = 3'd1,
        M_CRLF   = 3'd2,
        M_O      = 3'd3,
        M_OK     = 3'd4,
        M_OK_CR  = 3'd5
    } match_state_t;

    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [7:0]  CH_O        = 8'h4F;
    localparam logic [7:0]  CH_K        = 8'h4B;
    localparam logic [15:0] TICK_MS     = 16'd10;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // Result queue: four entries, two-bit indexes, three-bit count
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_IDX_W = 2;
    localparam int unsigned RES_CNT_W = 3;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  rx_byte;
        logic [15:0] limit_ms;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       wait_done;
        logic       wait_failed;
        logic       ok_seen;
        logic       waiting;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/uart_response_ok_detector.sv -----
// uart_response_ok_detector: receive ring, OK-response matcher and wait timer.
// Depends on uok_pkg (item/result word types, matcher states, constants).
`default_nettype none

// Receive side of a modem command link. Each input word is one of: a received
// byte (stored in a DEPTH-entry ring that holds at most DEPTH-1 bytes; a byte
// arriving on a full ring is dropped but still seen by the matcher), a read
// request (pops the oldest byte, or returns 0 with read_valid low when empty),
// a start-wait (clears the ok flag and arms a timeout in ms, ending at once
// when the timeout is 0), or a 10 ms tick (while a wait is pending, advances
// the elapsed time, saturating at 65535, and ends the wait when OK was seen or
// the timeout is reached). Ending a wait empties the ring. Every input word
// yields exactly one result word. One word is accepted per cycle while there is
// room; control state is updated at the accept edge, the ring memory is read
// there too; the result passes a pipe stage that registers the memory read,
// then a four-entry result queue. The input stalls while stage and queue hold
// four words. The ring is a single-port-write, single-port-read memory with
// registered read data and needs no clearing after reset.
module uart_response_ok_detector
    import uok_pkg::*;
#(
    parameter int unsigned DEPTH = 512
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg,  read_ptr_next;
    match_state_t     match_state_reg, match_state_next;
    logic             ok_flag_reg,     ok_flag_next;
    logic             wait_active_reg, wait_active_next;
    logic [15:0]      elapsed_reg,     elapsed_next;
    logic [15:0]      wait_limit_reg,  wait_limit_next;

    logic [7:0]       ring_mem [DEPTH];
    logic [7:0]       mem_q_reg;

    // Stage between accept and result queue (holds everything but the byte)
    logic             pipe_valid_reg;
    result_t          pipe_reg, pipe_next;

    // Result queue
    result_t              res_fifo_reg [RES_DEPTH];
    logic [RES_IDX_W-1:0] res_wr_reg, res_rd_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg;

    logic item_fire;
    logic result_fire;
    logic ring_write;
    logic ring_pop;
    logic ok_hit;
    logic done_c;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [16:0]      elapsed_sum;
    logic [15:0]      elapsed_tick;
    result_t          pipe_word;

    // Room for a new word as long as pipe stage plus queue stay within depth
    assign item_ready  = (res_cnt_reg + {{(RES_CNT_W-1){1'b0}}, pipe_valid_reg})
                         < RES_CNT_W'(RES_DEPTH);
    assign item_fire   = item_valid && item_ready;
    assign result_valid = (res_cnt_reg != '0);
    assign result_fire = result_valid && result_ready;
    assign result      = res_fifo_reg[res_rd_reg];

    assign wr_ptr_inc  = (write_ptr_reg == PTR_LAST) ? '0 : write_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc  = (read_ptr_reg  == PTR_LAST) ? '0 : read_ptr_reg  + PTR_W'(1);

    assign elapsed_sum  = {1'b0, elapsed_reg} + {1'b0, TICK_MS};
    assign elapsed_tick = elapsed_sum[16] ? ELAPSED_MAX : elapsed_sum[15:0];

    // ---------------------------------------------------------------
    // Matcher: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        unique case (match_state_reg)
            M_CR:
            begin
                match_state_next = (item.rx_byte == CH_LF) ? M_CRLF : M_CR;
            end
            M_CRLF:
            begin
                if (item.rx_byte == CH_O)
                    match_state_next = M_O;
                else if (item.rx_byte == CH_CR)
                    match_state_next = M_CR;
                else
                    match_state_next = M_IDLE;
            end
            M_O:
            begin
                if (item.rx_byte == CH_K)
                    match_state_next = M_OK;
                else if (item.rx_byte == CH_CR)
                    match_state_next = M_CR;
                else
                    match_state_next = M_IDLE;
            end
            M_OK:
            begin
                match_state_next = (item.rx_byte == CH_CR) ? M_OK_CR : M_IDLE;
            end
            M_OK_CR:
            begin
                match_state_next = M_IDLE;
            end
            default:
            begin
                // idle, and the two unused codes
                match_state_next = (item.rx_byte == CH_CR) ? M_CR : M_IDLE;
            end
        endcase
    end

    // Matcher: output (full sequence seen on this byte)
    always_comb
    begin
        unique case (match_state_reg)
            M_OK_CR: ok_hit = (item.rx_byte == CH_LF);
            default: ok_hit = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Item processing
    // ---------------------------------------------------------------
    always_comb
    begin
        write_ptr_next   = write_ptr_reg;
        read_ptr_next    = read_ptr_reg;
        ok_flag_next     = ok_flag_reg;
        wait_active_next = wait_active_reg;
        elapsed_next     = elapsed_reg;
        wait_limit_next  = wait_limit_reg;
        ring_write       = 1'b0;
        ring_pop         = 1'b0;
        done_c           = 1'b0;

        case (item.kind)
            KIND_RX_BYTE:
            begin
                if (wr_ptr_inc != read_ptr_reg)
                begin
                    ring_write     = 1'b1;
                    write_ptr_next = wr_ptr_inc;
                end
                if (ok_hit)
                    ok_flag_next = 1'b1;
            end
            KIND_READ:
            begin
                if (read_ptr_reg != write_ptr_reg)
                begin
                    ring_pop      = 1'b1;
                    read_ptr_next = rd_ptr_inc;
                end
            end
            KIND_START_WAIT:
            begin
                ok_flag_next     = 1'b0;
                elapsed_next     = '0;
                wait_limit_next  = item.limit_ms;
                wait_active_next = 1'b1;
                done_c           = (item.limit_ms == '0);
            end
            default:
            begin
                // tick: only counts while a wait is pending
                if (wait_active_reg)
                begin
                    elapsed_next = elapsed_tick;
                    done_c = ok_flag_reg || (elapsed_tick >= wait_limit_reg);
                end
            end
        endcase

        // Ending a wait drops whatever the ring holds
        if (done_c)
        begin
            read_ptr_next    = write_ptr_next;
            wait_active_next = 1'b0;
        end

        pipe_next.read_data   = '0;
        pipe_next.read_valid  = ring_pop;
        pipe_next.wait_done   = done_c;
        pipe_next.wait_failed = done_c && !ok_flag_next;
        pipe_next.ok_seen     = ok_flag_next;
        pipe_next.waiting     = wait_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg   <= '0;
            read_ptr_reg    <= '0;
            match_state_reg <= M_IDLE;
            ok_flag_reg     <= 1'b0;
            wait_active_reg <= 1'b0;
            elapsed_reg     <= '0;
            wait_limit_reg  <= '0;
        end
        else if (item_fire)
        begin
            write_ptr_reg   <= write_ptr_next;
            read_ptr_reg    <= read_ptr_next;
            ok_flag_reg     <= ok_flag_next;
            wait_active_reg <= wait_active_next;
            elapsed_reg     <= elapsed_next;
            wait_limit_reg  <= wait_limit_next;
            if (item.kind == KIND_RX_BYTE)
                match_state_reg <= match_state_next;
        end
    end

    // Ring memory: reads and writes never fall on the same word
    always_ff @(posedge clk)
    begin
        if (item_fire && ring_write)
            ring_mem[write_ptr_reg] <= item.rx_byte;
        if (item_fire && ring_pop)
            mem_q_reg <= ring_mem[read_ptr_reg];
    end

    // ---------------------------------------------------------------
    // Pipe stage and result queue
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_valid_reg <= 1'b0;
        else
            pipe_valid_reg <= item_fire;
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            pipe_reg <= pipe_next;
    end

    always_comb
    begin
        pipe_word = pipe_reg;
        pipe_word.read_data = pipe_reg.read_valid ? mem_q_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (pipe_valid_reg)
                res_wr_reg <= res_wr_reg + RES_IDX_W'(1);
            if (result_fire)
                res_rd_reg <= res_rd_reg + RES_IDX_W'(1);
            if (pipe_valid_reg && !result_fire)
                res_cnt_reg <= res_cnt_reg + RES_CNT_W'(1);
            else if (!pipe_valid_reg && result_fire)
                res_cnt_reg <= res_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_valid_reg)
            res_fifo_reg[res_wr_reg] <= pipe_word;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg + {{(RES_CNT_W-1){1'b0}}, pipe_valid_reg}) <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_done_empties: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && done_c |=> (read_ptr_reg == write_ptr_reg) && !wait_active_reg)
        else $error("ended wait left ring or wait state");

    a_read_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.read_valid && result.wait_done))
        else $error("read word also reports wait end");

    a_failed_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.wait_failed |-> result.wait_done && !result.ok_seen)
        else $error("wait_failed without wait_done");

endmodule

`default_nettype wire
